// ----- rtl/conditional_probability_table_macros.svh -----
// Assertion helpers for the conditional probability table checker
`ifndef CONDITIONAL_PROBABILITY_TABLE_MACROS_SVH
`define CONDITIONAL_PROBABILITY_TABLE_MACROS_SVH

// clocked on clk_i, off while rst_ni is low
`define CPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked on clk_i, checked through reset as well
`define CPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- rtl/cpt_pkg.sv -----
package cpt_pkg;

  localparam int PARENT_FIELDS = 4;
  localparam int FRAC_BITS     = 16;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SIZE  = 2'd2;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [2:0] REG_PARENT_COUNT = 3'd0;
  localparam logic [2:0] REG_VALUE_COUNT  = 3'd1;
  localparam logic [2:0] REG_RADIX_0      = 3'd2;
  localparam logic [2:0] REG_RADIX_1      = 3'd3;
  localparam logic [2:0] REG_RADIX_2      = 3'd4;
  localparam logic [2:0] REG_RADIX_3      = 3'd5;

  typedef struct packed {
    logic clr;
    logic load;
    logic walk;
    logic addr;
    logic rd;
    logic wr;
    logic dload;
    logic dstep;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic walk_done;
    logic err;
    logic is_read;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/conditional_probability_table.sv -----
// From start to done: if parent_count or value_count is too large the parent walk is skipped and
// the item is rejected in READ; other rejected items walk every parent first; samples go on to
// EVAL, reads on to a 16-step restoring divider. One transaction in flight; the next start is
// taken the cycle after done. The row index is built one parent per cycle. After reset both
// count stores are zeroed by a sweep over all MAX_ROWS * MAX_VALUES cell addresses with busy
// high; config writes are taken throughout. done is a one-cycle strobe, never stalled.
module conditional_probability_table import cpt_pkg::*; #(
  parameter int MAX_PARENTS = 4,
  parameter int MAX_VALUES  = 16,
  parameter int MAX_ROWS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [3:0]  node_value_i,
  input  logic [3:0]  parent_value_0_i,
  input  logic [3:0]  parent_value_1_i,
  input  logic [3:0]  parent_value_2_i,
  input  logic [3:0]  parent_value_3_i,
  output logic        done_o,
  output logic [16:0] probability_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  cpt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  cpt_datapath #(
    .MAX_PARENTS(MAX_PARENTS),
    .MAX_VALUES (MAX_VALUES),
    .MAX_ROWS   (MAX_ROWS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .node_value_i    (node_value_i),
    .parent_value_0_i(parent_value_0_i),
    .parent_value_1_i(parent_value_1_i),
    .parent_value_2_i(parent_value_2_i),
    .parent_value_3_i(parent_value_3_i),
    .probability_o   (probability_o),
    .status_o        (status_o)
  );

endmodule

// ----- rtl/cpt_ram.sv -----
module cpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/cpt_ctrl.sv -----
module cpt_ctrl import cpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WALK  = 4'd2;
  localparam logic [3:0] ST_ADDR  = 4'd3;
  localparam logic [3:0] ST_READ  = 4'd4;
  localparam logic [3:0] ST_EVAL  = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          state_d = ST_ADDR;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        if (sts_i.err) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_OUT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.is_read) begin
          cmd_o.dload = 1'b1;
          state_d     = ST_DIV;
        end else begin
          cmd_o.wr  = 1'b1;
          cmd_o.fin = 1'b1;
          state_d   = ST_OUT;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_OUT;
        end else begin
          cmd_o.dstep = 1'b1;
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_OUT);

endmodule

// ----- rtl/cpt_datapath.sv -----
module cpt_datapath import cpt_pkg::*; #(
  parameter int MAX_PARENTS = 4,
  parameter int MAX_VALUES  = 16,
  parameter int MAX_ROWS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        action_i,
  input  logic [3:0]  node_value_i,
  input  logic [3:0]  parent_value_0_i,
  input  logic [3:0]  parent_value_1_i,
  input  logic [3:0]  parent_value_2_i,
  input  logic [3:0]  parent_value_3_i,
  output logic [16:0] probability_o,
  output logic [1:0]  status_o
);

  localparam int CW           = COUNT_WIDTH;
  localparam int CELLS        = MAX_ROWS * MAX_VALUES;
  localparam int CELL_W       = $clog2(CELLS);
  localparam int ROW_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW           = $clog2(MAX_ROWS + 2);
  localparam int PARENT_LIMIT = (MAX_PARENTS < PARENT_FIELDS) ? MAX_PARENTS : PARENT_FIELDS;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + CW'(1);
  endfunction

  // configuration
  logic [2:0] parent_count_q;
  logic [4:0] value_count_q;
  logic [4:0] radix_q [PARENT_FIELDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parent_count_q <= 3'd0;
      value_count_q  <= 5'd2;
      for (int k = 0; k < PARENT_FIELDS; k++) begin
        radix_q[k] <= 5'd2;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PARENT_COUNT: parent_count_q <= cfg_data_i[2:0];
        REG_VALUE_COUNT:  value_count_q  <= cfg_data_i;
        REG_RADIX_0:      radix_q[0]     <= cfg_data_i;
        REG_RADIX_1:      radix_q[1]     <= cfg_data_i;
        REG_RADIX_2:      radix_q[2]     <= cfg_data_i;
        REG_RADIX_3:      radix_q[3]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured transaction
  logic       action_q;
  logic [3:0] nv_q;
  logic [3:0] pv_q [PARENT_FIELDS];

  // index walk and divider
  logic [4:0]        idx_q;
  logic [RW-1:0]     rows_q;
  logic [ROW_W-1:0]  row_q;
  logic [CELL_W-1:0] cell_q;
  logic              over_q;
  logic              oor_q;
  logic [CW-1:0]     rem_q;
  logic [CW-1:0]     den_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic              ge_q;
  logic [CELL_W-1:0] clr_q;
  logic [16:0]       prob_q;
  logic [1:0]        status_q;

  logic [4:0]          cur_radix;
  logic [3:0]          cur_pv;
  logic [RW+4:0]       rows_prod;
  logic [ROW_W+4:0]    row_prod;
  logic [CELL_W+4:0]   cell_full;
  logic [1:0]          code;
  logic [CW-1:0]       cell_rdata;
  logic [CW-1:0]       row_rdata;
  logic [CW-1:0]       num_mux;
  logic [CW-1:0]       den_mux;
  logic [CW:0]         rem2;
  logic [CW:0]         rem_sub;
  logic                rem_ge;

  assign cur_radix = radix_q[idx_q[1:0]];
  assign cur_pv    = pv_q[idx_q[1:0]];
  assign rows_prod = (RW+5)'(rows_q) * (RW+5)'(cur_radix);
  assign row_prod  = (ROW_W+5)'(row_q) * (ROW_W+5)'(cur_radix) + (ROW_W+5)'(cur_pv);
  assign cell_full = (CELL_W+5)'(row_q) * (CELL_W+5)'(MAX_VALUES) + (CELL_W+5)'(nv_q);

  assign code = over_q ? STATUS_SIZE : (oor_q ? STATUS_RANGE : STATUS_OK);

  assign num_mux = (row_rdata == '0) ? CW'(1) : cell_rdata;
  assign den_mux = (row_rdata == '0) ? CW'(value_count_q) : row_rdata;

  assign rem2    = {rem_q, 1'b0};
  assign rem_ge  = rem2 >= {1'b0, den_q};
  assign rem_sub = rem2 - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + CELL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      nv_q     <= node_value_i;
      pv_q[0]  <= parent_value_0_i;
      pv_q[1]  <= parent_value_1_i;
      pv_q[2]  <= parent_value_2_i;
      pv_q[3]  <= parent_value_3_i;
      idx_q    <= '0;
      rows_q   <= RW'(1);
      row_q    <= '0;
      oor_q    <= {1'b0, node_value_i} >= value_count_q;
      over_q   <= (parent_count_q > 3'(PARENT_LIMIT)) ||
                  ({4'b0, value_count_q} > 9'(MAX_VALUES));
    end else if (cmd_i.walk) begin
      idx_q <= idx_q + 5'd1;
      rows_q <= (rows_prod > (RW+5)'(MAX_ROWS + 1)) ? RW'(MAX_ROWS + 1) : rows_prod[RW-1:0];
      row_q <= row_prod[ROW_W-1:0];
      if ({1'b0, cur_pv} >= cur_radix) begin
        oor_q <= 1'b1;
      end
    end else if (cmd_i.addr) begin
      if (rows_q > RW'(MAX_ROWS)) begin
        over_q <= 1'b1;
      end
      cell_q <= cell_full[CELL_W-1:0];
    end else if (cmd_i.dload) begin
      rem_q <= num_mux;
      den_q <= den_mux;
      ge_q  <= num_mux >= den_mux;
      idx_q <= '0;
    end else if (cmd_i.dstep) begin
      rem_q <= rem_ge ? rem_sub[CW-1:0] : rem2[CW-1:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
      idx_q <= idx_q + 5'd1;
    end
    if (cmd_i.fin) begin
      status_q <= code;
      if ((code != STATUS_OK) || (action_q == ACT_SAMPLE)) begin
        prob_q <= '0;
      end else begin
        prob_q <= ge_q ? ONE_Q16 : {1'b0, quo_q};
      end
    end
  end

  cpt_ram #(
    .WIDTH(CW),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.clr | cmd_i.wr),
    .waddr_i(cmd_i.clr ? clr_q : cell_q),
    .wdata_i(cmd_i.clr ? '0 : sat_inc(cell_rdata)),
    .re_i   (cmd_i.rd),
    .raddr_i(cell_q),
    .rdata_o(cell_rdata)
  );

  cpt_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_ROWS)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   ((cmd_i.clr & (clr_q < CELL_W'(MAX_ROWS))) | cmd_i.wr),
    .waddr_i(cmd_i.clr ? clr_q[ROW_W-1:0] : row_q),
    .wdata_i(cmd_i.clr ? '0 : sat_inc(row_rdata)),
    .re_i   (cmd_i.rd),
    .raddr_i(row_q),
    .rdata_o(row_rdata)
  );

  assign sts_o.clr_done  = (clr_q == CELL_W'(CELLS - 1));
  assign sts_o.walk_done = over_q || (idx_q == {2'b0, parent_count_q});
  assign sts_o.err       = (code != STATUS_OK);
  assign sts_o.is_read   = (action_q == ACT_READ);
  assign sts_o.div_done  = ge_q || (idx_q == 5'(FRAC_BITS));

  assign probability_o = prob_q;
  assign status_o      = status_q;

endmodule

// ----- rtl/cpt_checker.sv -----
`include "conditional_probability_table_macros.svh"

module cpt_checker import cpt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [16:0] probability_o,
  input logic [1:0]  status_o
);

  `CPT_ASSERT(a_done_while_busy, done_o |-> busy_o, "result strobe outside a transaction")
  `CPT_ASSERT(a_idle_after_done, done_o |=> !busy_o, "block not idle after result")
  `CPT_ASSERT(a_busy_after_start, (start_i && !busy_o) |=> busy_o, "start not taken")
  `CPT_ASSERT(a_error_prob_zero, (done_o && status_o != STATUS_OK) |-> probability_o == '0, "nonzero probability on error")
  `CPT_ASSERT(a_prob_bounded, done_o |-> probability_o <= ONE_Q16, "probability above one")

endmodule

bind conditional_probability_table cpt_checker u_cpt_checker (.*);

// ----- sim/tb_conditional_probability_table.sv -----
module tb_conditional_probability_table;
  timeunit 1ns;
  timeprecision 1ps;

  import cpt_pkg::*;

  localparam int MAX_PARENTS = 4;
  localparam int MAX_VALUES  = 16;
  localparam int MAX_ROWS    = 256;
  localparam int COUNT_WIDTH = 32;

  // indexes past the last radix register; writes there must be ignored
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic            action;
    logic [3:0]      node;
    logic [3:0][3:0] parent;
  } query_t;

  typedef struct packed {
    logic [16:0] prob;
    logic [1:0]  status;
  } outcome_t;

  class cpt_scoreboard;
    logic [2:0]             parents_used;
    logic [4:0]             node_values;
    logic [4:0]             radix [PARENT_FIELDS];
    logic [COUNT_WIDTH-1:0] cell_tally [MAX_ROWS*MAX_VALUES];
    logic [COUNT_WIDTH-1:0] row_tally [MAX_ROWS];
    outcome_t               expected_q [$];
    int                     errors;
    int                     samples;
    int                     reads;
    int                     status_seen [3];

    function new();
      parents_used = 3'd0;
      node_values  = 5'd2;
      foreach (radix[i]) radix[i] = 5'd2;
      foreach (cell_tally[i]) cell_tally[i] = '0;
      foreach (row_tally[i]) row_tally[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      errors  = 0;
      samples = 0;
      reads   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [4:0] data);
      case (idx)
        REG_PARENT_COUNT: parents_used = data[2:0];
        REG_VALUE_COUNT:  node_values = data;
        REG_RADIX_0:      radix[0] = data;
        REG_RADIX_1:      radix[1] = data;
        REG_RADIX_2:      radix[2] = data;
        REG_RADIX_3:      radix[3] = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(query_t q);
      longint unsigned rows;
      longint unsigned row;
      longint unsigned cnt;
      longint unsigned total;
      longint unsigned quo;
      int              slot;
      int              i;
      outcome_t        res;
      rows = 1;
      row = 0;
      res.prob = '0;
      res.status = STATUS_OK;
      if (parents_used > MAX_PARENTS || parents_used > PARENT_FIELDS ||
          node_values > MAX_VALUES) begin
        res.status = STATUS_SIZE;
      end else begin
        for (i = 0; i < parents_used; i++) rows *= radix[i];
        if (rows > MAX_ROWS) res.status = STATUS_SIZE;
      end
      if (res.status == STATUS_OK) begin
        if (q.node >= node_values) res.status = STATUS_RANGE;
        for (i = 0; i < parents_used; i++)
          if (q.parent[i] >= radix[i]) res.status = STATUS_RANGE;
      end
      if (res.status == STATUS_OK) begin
        for (i = 0; i < parents_used; i++) row = row * radix[i] + q.parent[i];
        slot = int'(row) * MAX_VALUES + q.node;
        if (q.action == ACT_SAMPLE) begin
          if (cell_tally[slot] != '1) cell_tally[slot]++;
          if (row_tally[row] != '1) row_tally[row]++;
        end else begin
          total = row_tally[row];
          cnt = cell_tally[slot];
          if (total == 0) begin
            quo = ONE_Q16 / node_values;
          end else begin
            quo = (cnt / total) * ONE_Q16 + ((cnt % total) << FRAC_BITS) / total;
            if (quo > ONE_Q16) quo = ONE_Q16;
          end
          res.prob = quo[16:0];
        end
      end
      if (q.action == ACT_SAMPLE) samples++;
      else reads++;
      status_seen[res.status]++;
      expected_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] check failed: %s", $time, what);
    endtask

    task check_result(logic [16:0] prob, logic [1:0] status);
      outcome_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, prob=%0d status=%0d", prob, status));
        return;
      end
      want = expected_q.pop_front();
      if (prob !== want.prob)
        report($sformatf("probability %0d, want %0d", prob, want.prob));
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        action_i = 1'b0;
  logic [3:0]  node_value_i = '0;
  logic [3:0]  parent_value_0_i = '0;
  logic [3:0]  parent_value_1_i = '0;
  logic [3:0]  parent_value_2_i = '0;
  logic [3:0]  parent_value_3_i = '0;
  logic        done_o;
  logic [16:0] probability_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  cpt_scoreboard sb = new();
  int            idle_pct = 0;
  int            settings_done = 0;
  int            idle_plan [4] = '{0, 76, 0, 35};
  bit            drain_first = 1'b0;

  conditional_probability_table #(
    .MAX_PARENTS(MAX_PARENTS),
    .MAX_VALUES (MAX_VALUES),
    .MAX_ROWS   (MAX_ROWS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(probability_o, status_o);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(input int pc, input int vc, input int r0, input int r1,
                               input int r2, input int r3);
    logic [2:0] ids [7];
    logic [4:0] vals [7];
    ids  = '{REG_PARENT_COUNT, REG_VALUE_COUNT, REG_RADIX_0, REG_RADIX_1, REG_RADIX_2,
             REG_RADIX_3, ($urandom_range(0, 1) != 0) ? REG_SPARE_7 : REG_SPARE_6};
    vals = '{5'(pc), 5'(vc), 5'(r0), 5'(r1), 5'(r2), 5'(r3), 5'($urandom)};
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy_o);
    foreach (ids[i]) write_reg(ids[i], vals[i]);
    cfg_valid_i <= 1'b0;
    idle_pct = idle_plan[settings_done % 4];
    settings_done++;
  endtask

  task automatic send_item(input logic act, input logic [3:0] nv, input logic [3:0] p0,
                           input logic [3:0] p1, input logic [3:0] p2, input logic [3:0] p3);
    query_t q;
    q.action = act;
    q.node   = nv;
    q.parent = {p3, p2, p1, p0};
    while ((drain_first && sb.pending() != 0) || $urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    drain_first = 1'b0;
    start_i          <= 1'b1;
    action_i         <= act;
    node_value_i     <= nv;
    parent_value_0_i <= p0;
    parent_value_1_i <= p1;
    parent_value_2_i <= p2;
    parent_value_3_i <= p3;
    do @(posedge clk_i); while (busy_o);
    sb.note_input(q);
  endtask

  // mostly in-range rows and values so counts build up; the rest is raw noise
  task automatic random_items(input int n);
    logic       act;
    logic [3:0] nv;
    logic [3:0] pv [4];
    int         i;
    repeat (n) begin
      act = ($urandom_range(0, 99) < 55) ? ACT_SAMPLE : ACT_READ;
      nv = 4'($urandom);
      foreach (pv[k]) pv[k] = 4'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        if (sb.node_values != 0)
          nv = 4'($urandom_range(0, (sb.node_values > 16) ? 15 : sb.node_values - 1));
        for (i = 0; i < PARENT_FIELDS; i++)
          if (sb.radix[i] != 0)
            pv[i] = 4'($urandom_range(0, (sb.radix[i] > 16) ? 15 : sb.radix[i] - 1));
      end
      if ($urandom_range(0, 99) < 3) drain_first = 1'b1;
      send_item(act, nv, pv[0], pv[1], pv[2], pv[3]);
    end
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_setting(0, 2, 2, 2, 2, 2);
    send_item(ACT_READ, 0, 0, 0, 0, 0);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 0, 0, 0);
    send_item(ACT_READ, 1, 0, 0, 0, 0);
    send_item(ACT_SAMPLE, 1, 15, 15, 15, 15);
    send_item(ACT_READ, 0, 15, 15, 15, 15);
    send_item(ACT_SAMPLE, 2, 0, 0, 0, 0);
    send_item(ACT_READ, 15, 0, 0, 0, 0);
    random_items(60);

    apply_setting(4, 16, 4, 4, 4, 4);
    send_item(ACT_READ, 15, 3, 3, 3, 3);
    send_item(ACT_SAMPLE, 15, 3, 3, 3, 3);
    send_item(ACT_READ, 15, 3, 3, 3, 3);
    send_item(ACT_SAMPLE, 0, 4, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 0, 0, 4);
    random_items(100);

    apply_setting(1, 1, 31, 2, 2, 2);
    send_item(ACT_READ, 0, 15, 0, 0, 0);
    send_item(ACT_READ, 1, 0, 0, 0, 0);
    random_items(40);

    apply_setting(4, 16, 4, 4, 4, 5);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 0);
    random_items(10);

    apply_setting(7, 2, 2, 2, 2, 2);
    send_item(ACT_READ, 0, 0, 0, 0, 0);
    apply_setting(5, 2, 1, 1, 1, 1);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 0);
    random_items(10);

    apply_setting(0, 17, 2, 2, 2, 2);
    send_item(ACT_READ, 0, 0, 0, 0, 0);
    apply_setting(0, 0, 2, 2, 2, 2);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 0);
    random_items(10);

    apply_setting(2, 4, 3, 0, 2, 2);
    send_item(ACT_SAMPLE, 1, 1, 0, 0, 0);
    random_items(10);

    apply_setting(4, 31, 31, 31, 31, 31);
    send_item(ACT_READ, 0, 0, 0, 0, 0);
    random_items(10);

    apply_setting(4, 8, 16, 1, 16, 1);
    send_item(ACT_SAMPLE, 7, 15, 0, 15, 0);
    send_item(ACT_READ, 7, 15, 0, 15, 0);
    random_items(80);

    apply_setting(2, 3, 3, 5, 2, 2);
    random_items(120);
    apply_setting(3, 16, 2, 1, 3, 2);
    random_items(100);
    apply_setting(1, 2, 2, 2, 2, 2);
    random_items(80);
    repeat (2) begin
      apply_setting($urandom_range(0, 4), $urandom_range(1, 16), $urandom_range(1, 5),
                    $urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5));
      random_items(40);
    end

    start_i <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (32) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Covered %0d samples and %0d reads over %0d register settings, idle 0/35/76%%",
             sb.samples, sb.reads, settings_done);
    $display("Expected status mix: %0d ok, %0d out of range, %0d table too large",
             sb.status_seen[STATUS_OK], sb.status_seen[STATUS_RANGE],
             sb.status_seen[STATUS_SIZE]);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cpt_pkg.sv
rtl/cpt_ram.sv
rtl/cpt_ctrl.sv
rtl/cpt_datapath.sv
rtl/conditional_probability_table.sv
rtl/cpt_checker.sv
sim/tb_conditional_probability_table.sv
